// File: rtl/elpr_pkg.sv
// Package for the edge list parser with dense renumbering.
// Holds the shared types, result kind codes and fixed constants.
// No dependencies.
package elpr_pkg;

  localparam int TEXT_W = 8;
  localparam int ACC_W = 13;
  localparam int SRC_RAW_W = 12;
  localparam int ID_W = 13;
  localparam int OUT_ID_W = 12;
  localparam int CFG_W = 13;
  localparam int REG_IDX_W = 1;
  localparam int EPOCH_W = 8;
  localparam int MAX_RES = 3;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = 3;
  localparam int OQ_CNT_W = 4;
  localparam int DEC_RADIX = 10;

  localparam logic [TEXT_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [TEXT_W-1:0] CHAR_NINE = 8'd57;
  localparam logic [ACC_W-1:0] ACC_SAT = 13'd8191;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 13'd4096;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = 8'hFF;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NODE_COUNT    = 1'b0,
    REG_DIRECTED_MODE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    kind_t                kind;
    logic [OUT_ID_W-1:0]  tgt;
    logic [OUT_ID_W-1:0]  src;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [1:0]                cnt;
    result_t [MAX_RES-1:0]     res;
  } push_t;

  typedef struct packed {
    logic                  valid;
    logic                  pair;
    logic                  err;
    logic                  eoi;
    logic [SRC_RAW_W-1:0]  src_raw;
    logic [ACC_W-1:0]      tgt_raw;
  } lookup_req_t;

  typedef struct packed {
    logic clearing;
    logic s1_pair;
  } remap_stat_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [ID_W-1:0]    id;
  } remap_ent_t;

endpackage

// File: rtl/elpr_ram.sv
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
module elpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/elpr_parse.sv
// Byte parser: accumulates decimal numbers, checks their range and pairs them.
// Issues one lookup request per accepted byte. Depends on elpr_pkg.
module elpr_parse
  import elpr_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [TEXT_W-1:0]   text_byte,
  input  logic                end_of_input,
  input  logic [CFG_W-1:0]    node_count,
  output lookup_req_t         req
);

  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic                 in_num_r, in_num_nxt;
  logic                 have_src_r, have_src_nxt;
  logic [SRC_RAW_W-1:0] pend_src_r, pend_src_nxt;
  logic                 stop_r, stop_nxt;

  logic                 digit;
  logic [TEXT_W-1:0]    dig_val;
  logic [ACC_W+3:0]     prod;
  logic [ACC_W-1:0]     acc_dig;
  logic [ACC_W-1:0]     val;
  logic                 num_now;
  logic                 finish;
  logic                 out_of_range;
  logic                 err;
  logic                 take_src;
  logic                 pair;

  always_comb begin
    digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    dig_val = text_byte - CHAR_ZERO;
    prod = (ACC_W+4)'(acc_r) * (ACC_W+4)'(DEC_RADIX) + (ACC_W+4)'(dig_val[3:0]);
    acc_dig = (prod > (ACC_W+4)'(ACC_SAT)) ? ACC_SAT : prod[ACC_W-1:0];
    val = digit ? acc_dig : acc_r;
    num_now = in_num_r || digit;
    finish = !stop_r && num_now && (!digit || end_of_input);
    out_of_range = (val >= ACC_SAT) || (val >= node_count) || (32'(val) >= MAX_NODES);
    err = finish && out_of_range;
    take_src = finish && !out_of_range && !have_src_r;
    pair = finish && !out_of_range && have_src_r;
  end

  always_comb begin
    acc_nxt = acc_r;
    in_num_nxt = in_num_r;
    have_src_nxt = have_src_r;
    pend_src_nxt = pend_src_r;
    stop_nxt = stop_r;
    if (accept) begin
      if (end_of_input) begin
        acc_nxt = '0;
        in_num_nxt = 1'b0;
        have_src_nxt = 1'b0;
        pend_src_nxt = '0;
        stop_nxt = 1'b0;
      end else if (!stop_r) begin
        acc_nxt = finish ? '0 : val;
        in_num_nxt = finish ? 1'b0 : num_now;
        if (err) begin
          stop_nxt = 1'b1;
        end
        if (take_src) begin
          pend_src_nxt = val[SRC_RAW_W-1:0];
          have_src_nxt = 1'b1;
        end
        if (pair) begin
          have_src_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      in_num_r <= 1'b0;
      have_src_r <= 1'b0;
      pend_src_r <= '0;
      stop_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      in_num_r <= in_num_nxt;
      have_src_r <= have_src_nxt;
      pend_src_r <= pend_src_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_comb begin
    req.valid = accept;
    req.pair = pair;
    req.err = err;
    req.eoi = end_of_input;
    req.src_raw = pend_src_r;
    req.tgt_raw = val;
  end

endmodule

// File: rtl/elpr_remap.sv
// Dense id remapping over two mirrored remap RAMs tagged with a text epoch.
// Resolves both ends of a pair in the cycle after the read, builds the results.
// Depends on elpr_pkg and elpr_ram.
module elpr_remap
  import elpr_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  lookup_req_t  req,
  input  logic         directed_mode,
  output push_t        push,
  output remap_stat_t  stat
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int ENT_W = $bits(remap_ent_t);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

  logic                 s1_pair_r, s1_err_r, s1_eoi_r;
  logic [AW-1:0]        s1_src_r, s1_tgt_r;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;
  logic [ID_W-1:0]      next_id_r, next_id_nxt;
  logic                 clr_r, clr_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                 pend_v_r;
  logic [AW-1:0]        pend_addr_r;
  remap_ent_t           pend_ent_r;

  logic                 rd_en;
  logic [AW-1:0]        rd_src, rd_tgt;
  logic [ENT_W-1:0]     s_raw, t_raw;
  remap_ent_t           s_rd, t_rd;
  logic                 s_hit, t_hit, same;
  logic [ID_W-1:0]      s_id, t_id, id_mid, id_end;
  logic                 s_we, pend_nxt;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  remap_ent_t           ram_wdata;
  logic [1:0]           idx;

  assign rd_en = req.valid && req.pair;
  assign rd_src = AW'(req.src_raw);
  assign rd_tgt = AW'(req.tgt_raw);

  elpr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_ram_src (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_src),
    .rdata (s_raw)
  );

  elpr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_ram_tgt (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_tgt),
    .rdata (t_raw)
  );

  assign s_rd = s_raw;
  assign t_rd = t_raw;

  // The source is numbered first; a self loop reuses the source id.
  always_comb begin
    s_hit = (s_rd.epoch == epoch_r);
    s_id = s_hit ? s_rd.id : next_id_r;
    id_mid = s_hit ? next_id_r : next_id_r + ID_W'(1);
    same = (s1_src_r == s1_tgt_r);
    t_hit = same || (t_rd.epoch == epoch_r);
    t_id = same ? s_id : (t_hit ? t_rd.id : id_mid);
    id_end = t_hit ? id_mid : id_mid + ID_W'(1);
    s_we = s1_pair_r && !s1_eoi_r && !s_hit;
    pend_nxt = s1_pair_r && !s1_eoi_r && !t_hit;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = s1_src_r;
    ram_wdata.epoch = epoch_r;
    ram_wdata.id = next_id_r;
    if (clr_r) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (s_we) begin
      ram_we = 1'b1;
    end else if (pend_v_r) begin
      ram_we = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_ent_r;
    end
  end

  always_comb begin
    epoch_nxt = epoch_r;
    next_id_nxt = next_id_r;
    clr_nxt = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_nxt = 1'b0;
      end
    end
    if (s1_eoi_r) begin
      next_id_nxt = '0;
      if (epoch_r == EPOCH_LAST) begin
        epoch_nxt = EPOCH_FIRST;
        clr_nxt = 1'b1;
        clr_addr_nxt = '0;
      end else begin
        epoch_nxt = epoch_r + EPOCH_W'(1);
      end
    end else if (s1_pair_r) begin
      next_id_nxt = id_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pair_r <= 1'b0;
      s1_err_r <= 1'b0;
      s1_eoi_r <= 1'b0;
      epoch_r <= EPOCH_FIRST;
      next_id_r <= '0;
      clr_r <= 1'b1;
      clr_addr_r <= '0;
      pend_v_r <= 1'b0;
    end else begin
      s1_pair_r <= req.valid && req.pair;
      s1_err_r <= req.valid && req.err;
      s1_eoi_r <= req.valid && req.eoi;
      epoch_r <= epoch_nxt;
      next_id_r <= next_id_nxt;
      clr_r <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      pend_v_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_src_r <= rd_src;
      s1_tgt_r <= rd_tgt;
    end
    pend_addr_r <= s1_tgt_r;
    pend_ent_r.epoch <= epoch_r;
    pend_ent_r.id <= id_mid;
  end

  always_comb begin
    push = '0;
    idx = '0;
    if (s1_err_r) begin
      push.res[idx].kind = KIND_ERROR;
      idx = idx + 2'd1;
    end
    if (s1_pair_r) begin
      push.res[idx].kind = KIND_EDGE;
      push.res[idx].src = s_id[OUT_ID_W-1:0];
      push.res[idx].tgt = t_id[OUT_ID_W-1:0];
      idx = idx + 2'd1;
      if (!directed_mode) begin
        push.res[idx].kind = KIND_EDGE;
        push.res[idx].src = t_id[OUT_ID_W-1:0];
        push.res[idx].tgt = s_id[OUT_ID_W-1:0];
        idx = idx + 2'd1;
      end
    end
    if (s1_eoi_r) begin
      push.res[idx].kind = KIND_DONE;
      idx = idx + 2'd1;
    end
    if (idx != 2'd0) begin
      push.res[idx - 2'd1].last = 1'b1;
    end
    push.cnt = idx;
  end

  assign stat.clearing = clr_r;
  assign stat.s1_pair = s1_pair_r;

endmodule

// File: rtl/elpr_outq.sv
// Result queue: takes up to three results per cycle, hands out one.
// Separates the output handshake from the lookup stage. Depends on elpr_pkg.
module elpr_outq
  import elpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  push_t                push,
  input  logic                 pop,
  output logic                 head_valid,
  output result_t              head,
  output logic [OQ_CNT_W-1:0]  count
);

  result_t                q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + OQ_PTR_W'(pop);
    cnt_nxt = cnt_r + OQ_CNT_W'(push.cnt) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(push.cnt)) begin
        q_r[wr_ptr_r + OQ_PTR_W'(k)] <= push.res[k];
      end
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head = q_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

// File: rtl/edge_list_parser_renumber_core.sv
// Edge list text parser with dense node renumbering, top level.
// Holds the configuration registers and ties parser, remap stage and queue.
// Depends on elpr_pkg, elpr_parse, elpr_remap, elpr_outq and elpr_ram.
//
// Usage: text enters one byte per transaction on the in_ channel; in_tlast
// marks the final byte of a text. Each transaction on the out_ channel is
// one result: out_tuser gives the kind (edge, done, error), out_tdata the
// source and target dense ids, out_tlast the last result of an input byte.
// Registers are written through cfg_wen, cfg_addr and cfg_wdata while idle;
// the user must keep to that; the block does not enforce it. Throughput is
// one byte per cycle while in_tready is high. Results of a byte go through
// the registered remap RAM read, then id resolution and the queue write.
// Node ids live in two mirrored RAMs tagged with a text epoch, so a new
// text needs no table sweep. After reset, and after every 255th text, a
// clearing pass writes every remap entry once, one per cycle, with in_tready
// low. The result queue holds eight entries; in_tready falls when it could
// not absorb three more results, so a stalled receiver stalls the input.
module edge_list_parser_renumber_core
  import elpr_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // text_byte
  input  logic                  in_tlast,   // end_of_input
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // edge_source [11:0], edge_target [23:12]
  output logic [1:0]            out_tuser,  // result_kind
  output logic                  out_tlast,  // last_of_run
  input  logic                  cfg_wen,
  input  logic [REG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [CFG_W-1:0]     node_count_r;
  logic                 directed_r;
  logic                 in_accept;
  lookup_req_t          req;
  push_t                push;
  remap_stat_t          stat;
  result_t              head;
  logic [OQ_CNT_W-1:0]  oq_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      directed_r <= 1'b1;
    end else if (cfg_wen) begin
      case (reg_idx_t'(cfg_addr))
        REG_NODE_COUNT:    node_count_r <= cfg_wdata;
        REG_DIRECTED_MODE: directed_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !stat.clearing &&
                     ((oq_cnt + OQ_CNT_W'(push.cnt)) <= OQ_CNT_W'(OQ_DEPTH - MAX_RES));
  assign in_accept = in_tvalid && in_tready;

  elpr_parse #(.MAX_NODES(MAX_NODES)) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .text_byte    (in_tdata),
    .end_of_input (in_tlast),
    .node_count   (node_count_r),
    .req          (req)
  );

  elpr_remap #(.MAX_NODES(MAX_NODES)) u_remap (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .directed_mode (directed_r),
    .push          (push),
    .stat          (stat)
  );

  elpr_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tvalid && out_tready),
    .head_valid (out_tvalid),
    .head       (head),
    .count      (oq_cnt)
  );

  assign out_tdata = {head.tgt, head.src};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_cnt + OQ_CNT_W'(push.cnt)) <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_tready)
    else $error("input taken during remap clearing pass");

  a_no_pair_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.s1_pair |-> !stat.clearing)
    else $error("pair lookup overlaps remap clearing pass");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_DONE)) |-> out_tlast)
    else $error("done result not marked last");
`endif

endmodule

// File: tb/sv/elpr_tb_pkg.sv
// Scoreboard for the edge list parser with dense renumbering.
// Predicts the results of every accepted text byte and checks the result stream.
// Depends on elpr_pkg.
package elpr_tb_pkg;
  import elpr_pkg::*;

  localparam int unsigned NODE_LIMIT = 4096;

  class renumber_scoreboard;
    logic [CFG_W-1:0]     node_count;
    bit                   directed_mode;
    logic [ACC_W-1:0]     acc;
    bit                   in_number;
    bit                   have_source;
    bit                   stopped_on_error;
    logic [SRC_RAW_W-1:0] pending_source;
    logic [ID_W-1:0]      next_id;
    bit                   remap_valid [NODE_LIMIT];
    logic [ID_W-1:0]      remap_id [NODE_LIMIT];
    result_t              expected_results [$];
    int unsigned          mismatches;

    function new();
      node_count = NODE_COUNT_RST;
      directed_mode = 1'b1;
      mismatches = 0;
      clear_text();
    endfunction

    function void set_register(reg_idx_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_NODE_COUNT: node_count = value;
        REG_DIRECTED_MODE: directed_mode = value[0];
        default: ;
      endcase
    endfunction

    function void clear_text();
      acc = '0;
      in_number = 1'b0;
      have_source = 1'b0;
      stopped_on_error = 1'b0;
      pending_source = '0;
      next_id = '0;
      foreach (remap_valid[i]) remap_valid[i] = 1'b0;
    endfunction

    function logic [OUT_ID_W-1:0] dense_id(int unsigned raw);
      if (!remap_valid[raw]) begin
        remap_valid[raw] = 1'b1;
        remap_id[raw] = next_id;
        next_id = next_id + 1'b1;
      end
      return remap_id[raw][OUT_ID_W-1:0];
    endfunction

    static function result_t make_result(kind_t kind, logic [OUT_ID_W-1:0] src,
                                         logic [OUT_ID_W-1:0] tgt);
      result_t r;
      r.kind = kind;
      r.src = src;
      r.tgt = tgt;
      r.last = 1'b0;
      return r;
    endfunction

    function void predict_byte(logic [TEXT_W-1:0] text, bit eoi);
      result_t fresh [$];
      bit digit;
      bit finish;
      int unsigned sum;
      int unsigned val;
      logic [OUT_ID_W-1:0] s;
      logic [OUT_ID_W-1:0] t;
      digit = (text >= CHAR_ZERO) && (text <= CHAR_NINE);
      finish = 1'b0;
      val = 0;
      if (!stopped_on_error) begin
        if (digit) begin
          sum = int'(acc) * DEC_RADIX + int'(text - CHAR_ZERO);
          acc = (sum > ACC_SAT) ? ACC_SAT : sum[ACC_W-1:0];
          in_number = 1'b1;
        end
        if (in_number && (!digit || eoi)) begin
          finish = 1'b1;
          val = acc;
          acc = '0;
          in_number = 1'b0;
        end
      end
      if (finish) begin
        if (val >= ACC_SAT || val >= node_count || val >= NODE_LIMIT) begin
          fresh.insert(fresh.size(), make_result(KIND_ERROR, '0, '0));
          stopped_on_error = 1'b1;
        end else if (!have_source) begin
          pending_source = val[SRC_RAW_W-1:0];
          have_source = 1'b1;
        end else begin
          s = dense_id(pending_source);
          t = dense_id(val);
          have_source = 1'b0;
          fresh.insert(fresh.size(), make_result(KIND_EDGE, s, t));
          if (!directed_mode) fresh.insert(fresh.size(), make_result(KIND_EDGE, t, s));
        end
      end
      if (eoi) begin
        fresh.insert(fresh.size(), make_result(KIND_DONE, '0, '0));
        clear_text();
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) expected_results.insert(expected_results.size(), fresh[i]);
    endfunction

    function void check_result(logic [1:0] kind, logic [OUT_ID_W-1:0] src,
                               logic [OUT_ID_W-1:0] tgt, logic last);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, source %0d, target %0d", kind, src, tgt);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind) begin
        $error("result_kind: expected %0d, actual %0d", want.kind, kind);
        mismatches++;
      end
      if (src !== want.src) begin
        $error("edge_source: expected %0d, actual %0d", want.src, src);
        mismatches++;
      end
      if (tgt !== want.tgt) begin
        $error("edge_target: expected %0d, actual %0d", want.tgt, tgt);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/edge_list_parser_renumber_core_test.sv
// Top-level test for edge_list_parser_renumber_core: directed texts, then random
// texts under several register settings, with random stalls on both channels in all but the last phase.
// Depends on elpr_pkg, elpr_tb_pkg and the RTL of the block.
module edge_list_parser_renumber_core_test;
  import elpr_pkg::*;
  import elpr_tb_pkg::*;

  localparam logic [TEXT_W-1:0] SPACE = 8'h20;
  localparam logic [TEXT_W-1:0] NEWLINE = 8'h0A;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 14;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TEXT_W-1:0]    in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_wen = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = REG_NODE_COUNT;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  renumber_scoreboard sb;
  bit                 idle_on = 1'b1;
  int unsigned        live_items;
  logic [CFG_W-1:0]   cur_nodes = NODE_COUNT_RST;
  logic [TEXT_W-1:0]  text_bytes [$];
  logic [CFG_W-1:0]   phase_nodes [PHASES] = '{13'd4096, 13'd1, 13'd0, 13'd3, 13'd1, 13'd200};
  bit                 phase_directed [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  always #10 clk = ~clk;

  edge_list_parser_renumber_core #(
    .MAX_NODES(NODE_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_wen(cfg_wen),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata[11:0], out_tdata[23:12], out_tlast);
    end
  end

  task automatic send_byte(logic [TEXT_W-1:0] text, bit eoi);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= text;
    in_tlast <= eoi;
    do @(posedge clk); while (!in_tready);
    sb.predict_byte(text, eoi);
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) begin
      live_items++;
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
    text_bytes.delete();
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_W-1:0] nodes, bit directed);
    cfg_wen <= 1'b1;
    cfg_addr <= REG_NODE_COUNT;
    cfg_wdata <= nodes;
    @(posedge clk);
    cfg_addr <= REG_DIRECTED_MODE;
    cfg_wdata <= CFG_W'(directed);
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_register(REG_NODE_COUNT, nodes);
    sb.set_register(REG_DIRECTED_MODE, CFG_W'(directed));
    cur_nodes = nodes;
  endtask

  task automatic add_byte(logic [TEXT_W-1:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [TEXT_W-1:0] pick_separator();
    logic [TEXT_W-1:0] b;
    b = TEXT_W'($urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0) b = NEWLINE;
    else if (b >= CHAR_ZERO && b <= CHAR_NINE) b = SPACE;
    return b;
  endfunction

  function automatic int unsigned pick_node();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (cur_nodes == 0) return $urandom_range(0, 30);
    if (r < 5) return $urandom_range(0, ((cur_nodes < 6) ? cur_nodes : 6) - 1);
    if (r < 9) return $urandom_range(0, cur_nodes - 1);
    return cur_nodes + $urandom_range(0, 200);
  endfunction

  task automatic build_random_text();
    int unsigned shape;
    int unsigned count;
    shape = $urandom_range(0, 19);
    if (shape < 14) begin
      if ($urandom_range(0, 3) == 0) add_byte(pick_separator());
      count = 2 * $urandom_range(1, 4) + ($urandom_range(0, 5) == 0);
      for (int i = 0; i < count; i++) begin
        if (i > 0) repeat ($urandom_range(1, 2)) add_byte(pick_separator());
        if ($urandom_range(0, 7) == 0) add_byte(CHAR_ZERO);
        add_text($sformatf("%0d", pick_node()));
      end
      if ($urandom_range(0, 1) == 1) add_byte(pick_separator());
    end else if (shape < 17) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1) == 1) add_byte(CHAR_ZERO + TEXT_W'($urandom_range(0, 9)));
        else add_byte(TEXT_W'($urandom_range(0, 255)));
      end
    end else begin
      add_byte(CHAR_NINE);
      repeat ($urandom_range(3, 8)) add_byte(CHAR_ZERO + TEXT_W'($urandom_range(0, 9)));
      add_byte(pick_separator());
      add_text($sformatf("%0d", pick_node()));
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_config(NODE_COUNT_RST, 1'b1);

    // A leading separator, all-zero and all-one bytes, the largest id, leading zeros.
    add_byte(8'h00);
    add_text("0");
    add_byte(8'hFF);
    add_text("4095\n00 7");
    send_text();
    // Saturated number stops parsing until the final byte.
    add_text("99999/1:");
    send_text();
    // Out of range number completed by the final byte, then a dangling source,
    // then a text with no number at all.
    add_text("4096");
    send_text();
    add_text("5");
    send_text();
    add_text(" ");
    send_text();
    drain_results();

    live_items = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_config(phase_nodes[p], phase_directed[p]);
      if (p == PHASES - 1) idle_on = 1'b0;
      while (live_items < (p + 1) * ITEMS_PER_PHASE) begin
        build_random_text();
        send_text();
      end
      drain_results();
    end
    repeat (16) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/elpr_pkg.sv
rtl/elpr_ram.sv
rtl/elpr_parse.sv
rtl/elpr_remap.sv
rtl/elpr_outq.sv
rtl/edge_list_parser_renumber_core.sv
tb/sv/elpr_tb_pkg.sv
tb/sv/edge_list_parser_renumber_core_test.sv
